// ===== rtl/assert_macros.svh =====
// assertion macros shared by the floor match and remove rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define FMR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fmr assertion failed");
// antecedent in one cycle implies consequent in the next
`define FMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmr assertion failed");
`else
`define FMR_ASSERT(lbl, clk, rst_n, prop)
`define FMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/fmr_pkg.sv =====
// shared types and constants of the floor match and remove block
// no dependencies; imported by every module of the block
package fmr_pkg;

    // default table depth and price width
    localparam int FMR_ENTRIES = 1024;
    localparam int PRICE_W     = 32;
    localparam int STATUS_W    = 2;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_MATCH   = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming item, start a fresh search
        logic rd;        // read the table slot under the scan pointer
        logic load;      // append the captured price and report
        logic finish;    // retire the best match and report
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic scan_more; // scan pointer still below the fill count
    } t_sts;

endpackage

// ===== rtl/fmr_ctrl.sv =====
// controller of the floor match and remove block: sequences loads and offer scans
// depends on fmr_pkg and assert_macros.svh
`include "assert_macros.svh"
module fmr_ctrl import fmr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic i_mode,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy,
    output logic o_done
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_mode ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_done     = 1'b1;
                n_state    = S_IDLE;
            end
            S_SCAN: begin
                if (i_sts.scan_more) begin
                    o_cmd.rd = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

    // checks
    `FMR_ASSERT(a_done_src, i_clk, i_rst_n,
        !o_done || $past(r_state) == S_LOAD || $past(r_state) == S_DONE)
    `FMR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `FMR_ASSERT_NEXT(a_load_one, i_clk, i_rst_n, r_state == S_LOAD, o_done && !busy)
    `FMR_ASSERT_NEXT(a_scan_end, i_clk, i_rst_n,
        r_state == S_SCAN && !i_sts.scan_more, r_state == S_DONE)

endmodule

// ===== rtl/fmr_dpath.sv =====
// datapath of the floor match and remove block: price table, scan compare, results
// depends on fmr_pkg and assert_macros.svh
`include "assert_macros.svh"
module fmr_dpath import fmr_pkg::*; #(
    parameter int ENTRIES = FMR_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [PRICE_W-1:0]  i_amount,
    output t_sts                o_sts,
    output logic [STATUS_W-1:0] o_status,
    output logic [PRICE_W-1:0]  o_matched_price
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    // table word: valid mark over price
    logic [PRICE_W:0]   r_mem [ENTRIES];
    logic [PRICE_W:0]   r_rdata;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_addr;

    logic [CW-1:0]      r_fill;
    logic [CW-1:0]      r_addr;
    logic [PRICE_W-1:0] r_amount;
    logic               r_found;
    logic [PRICE_W-1:0] r_best;
    logic [AW-1:0]      r_best_slot;
    t_status            r_status;
    logic [PRICE_W-1:0] r_price;

    logic               w_full;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [PRICE_W:0]   w_wdata;
    logic [PRICE_W-1:0] w_rprice;
    logic               w_hit;

    assign w_full   = (r_fill == FULL_CNT);
    assign w_rprice = r_rdata[PRICE_W-1:0];

    // table write: append on load, clear valid mark on removal
    assign w_we    = (i_cmd.load && !w_full) || (i_cmd.finish && r_found);
    assign w_waddr = i_cmd.load ? r_fill[AW-1:0] : r_best_slot;
    assign w_wdata = i_cmd.load ? {1'b1, r_amount} : {1'b0, r_best};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // table read at the scan pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata   <= r_mem[r_addr[AW-1:0]];
            r_rd_addr <= r_addr[AW-1:0];
        end
    end

    // candidate: valid, fits the offer, strictly better than best so far
    assign w_hit = r_rd_vld && r_rdata[PRICE_W] && (w_rprice <= r_amount)
                   && (!r_found || (w_rprice > r_best));

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.load && !w_full) begin
                r_fill <= r_fill + CW'(1);
            end
            if (i_cmd.capture) begin
                r_found <= 1'b0;
            end else if (w_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    // item capture, scan pointer and best match
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_amount <= i_amount;
            r_addr   <= '0;
        end else if (i_cmd.rd) begin
            r_addr <= r_addr + CW'(1);
        end
        if (w_hit) begin
            r_best      <= w_rprice;
            r_best_slot <= r_rd_addr;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= w_full ? ST_FULL : ST_LOADED;
            r_price  <= '0;
        end else if (i_cmd.finish) begin
            r_status <= r_found ? ST_MATCH : ST_NOMATCH;
            r_price  <= r_found ? r_best : '0;
        end
    end

    assign o_sts.scan_more = (r_addr < r_fill);
    assign o_status        = r_status;
    assign o_matched_price = r_price;

    // checks
    `FMR_ASSERT(a_fill_range, i_clk, i_rst_n, r_fill <= FULL_CNT)
    `FMR_ASSERT(a_best_fits, i_clk, i_rst_n, !r_found || (r_best <= r_amount))
    `FMR_ASSERT_NEXT(a_rd_pipe, i_clk, i_rst_n, !i_cmd.rd, !r_rd_vld)

endmodule

// ===== rtl/floor_match_and_remove.sv =====
// Floor match and remove. A load item (mode 0) appends its price to the next
// free slot of the table: busy is high for one cycle and the result strobe
// o_done follows on the next. An offer item (mode 1) scans every slot handed
// out so far, one table read per cycle, and o_done rises in the same cycle
// that busy falls. The scan is bound by the single read port of the price
// table. Each result appears on o_status and o_matched_price in the cycle
// that o_done is high and is held until the next item reports; a new item
// may be started in the cycle that o_done is high. Slots are never reused,
// so the table reports full after ENTRIES loads. Valid marks need no clearing
// pass: only slots below the fill count are ever read.
// depends on fmr_pkg, fmr_ctrl and fmr_dpath
module floor_match_and_remove import fmr_pkg::*; #(
    parameter int ENTRIES = FMR_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_mode,
    input  logic [PRICE_W-1:0]  i_amount,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [PRICE_W-1:0]  o_matched_price
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencing
    fmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // table and search
    fmr_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_amount        (i_amount),
        .o_sts           (w_sts),
        .o_status        (o_status),
        .o_matched_price (o_matched_price)
    );

endmodule
